// ----- src/tfir_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfir_pkg: shared types and constants for the transposed-form FIR filter
// Item structs, datapath widths and the fixed coefficient table.
// ----------------------------------------------------------------------------
package tfir_pkg;

	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned COEF_W     = 16;
	localparam int unsigned ACC_W      = 48;
	localparam int unsigned OUT_LSB    = 16;
	localparam int unsigned OUT_W      = 32;
	localparam int unsigned COEF_COUNT = 73;
	localparam int unsigned COEF_IDX_W = 7;

	localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
		-16'sd137, -16'sd73, 16'sd139, 16'sd210, 16'sd384, 16'sd339, 16'sd263, 16'sd69,
		-16'sd15, 16'sd0, 16'sd177, 16'sd352, 16'sd424, 16'sd275, -16'sd20, -16'sd318,
		-16'sd420, -16'sd273, 16'sd21, 16'sd211, 16'sd86, -16'sd387, -16'sd991,
		-16'sd1380, -16'sd1294, -16'sd772, -16'sd175, -16'sd6, -16'sd582, -16'sd1761,
		-16'sd2918, -16'sd3223, -16'sd2086, 16'sd449, 16'sd3620, 16'sd6243, 16'sd7258,
		16'sd6243, 16'sd3620, 16'sd449, -16'sd2086, -16'sd3223, -16'sd2918, -16'sd1761,
		-16'sd582, -16'sd6, -16'sd175, -16'sd772, -16'sd1294, -16'sd1380, -16'sd991,
		-16'sd387, 16'sd86, 16'sd211, 16'sd21, -16'sd273, -16'sd420, -16'sd318, -16'sd20,
		16'sd275, 16'sd424, 16'sd352, 16'sd177, 16'sd0, -16'sd15, 16'sd69, 16'sd263,
		16'sd339, 16'sd384, 16'sd210, 16'sd139, -16'sd73, -16'sd137
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       end_of_frame;
	} tfir_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered;
		logic                    end_of_frame_out;
	} tfir_out_t;

	// per-cell controls, common to the whole row
	typedef struct packed {
		logic prod_en;
		logic ps_en;
		logic ps_clr;
	} tfir_ctl_t;

	// taps past the end of the table get a zero coefficient
	function automatic logic signed [COEF_W-1:0] tfir_coef(input int unsigned tap);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if (tap < COEF_COUNT) begin
			c = COEF_TABLE[tap[COEF_IDX_W-1:0]];
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- src/tfir_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfir_cell: one tap of the transposed-form FIR
// Registers coefficient times sample, and holds the partial sum handed in
// from the neighbor further down the chain.
// ----------------------------------------------------------------------------
module tfir_cell
	import tfir_pkg::*;
#(
	parameter logic signed [COEF_W-1:0] COEF = '0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tfir_ctl_t                  ctl,
	input  wire logic signed [SAMPLE_W-1:0] x,
	input  wire logic        [ACC_W-1:0]    sum_in,
	output      logic        [ACC_W-1:0]    sum_out
);

	logic signed [ACC_W-1:0] product;
	logic        [ACC_W-1:0] prod_s2;
	logic        [ACC_W-1:0] ps_q;

	// 32x16 signed, exact in 48 bits
	assign product = ACC_W'(x) * ACC_W'(COEF);

	always_ff @(posedge clk) begin
		if (ctl.prod_en) begin
			prod_s2 <= product;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= '0;
		end else if (ctl.ps_clr) begin
			ps_q <= '0;
		end else if (ctl.ps_en) begin
			ps_q <= sum_in;
		end
	end

	assign sum_out = ps_q + prod_s2;

endmodule
`default_nettype wire

// ----- src/transposed_fir_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transposed_fir_filter: TAPS-tap transposed-form FIR, fixed coefficients
// Sample register, a row of multiply/partial-sum cells, and an output register.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side is not stalled, and returns
// one item for each, through the sample register, the product registers and
// the output register. The rate is set by the row of tap cells: every cell
// multiplies the sample once into a registered product, and all partial sums
// advance together in one cycle. Outputs are bits 47..16 of the wrapped 48-bit
// sum. An end-of-frame item still gets its output and then zeroes every partial
// sum. Partial sums are zero after reset.
module transposed_fir_filter
	import tfir_pkg::*;
#(
	parameter int unsigned TAPS = 73
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire tfir_in_t  in_item,
	output      logic      out_valid,
	input  wire logic      out_ready,
	output      tfir_out_t out_item
);

	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       eof_s1;
	logic                       eof_s2;
	tfir_out_t                  out_s3;

	logic      adv1;
	logic      adv2;
	logic      adv3;
	logic      fire1;
	logic      fire2;
	tfir_ctl_t ctl;

	logic [ACC_W-1:0] chain [0:TAPS];

	// a stage may load when it is empty or its item moves on
	assign adv3  = !valid_s3 || out_ready;
	assign adv2  = !valid_s2 || adv3;
	assign adv1  = !valid_s1 || adv2;
	assign fire1 = valid_s1 && adv2;
	assign fire2 = valid_s2 && adv3;

	assign in_ready = adv1;

	assign ctl.prod_en = fire1;
	assign ctl.ps_en   = fire2;
	assign ctl.ps_clr  = fire2 && eof_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			sample_s1 <= in_item.sample;
			eof_s1    <= in_item.end_of_frame;
		end
		if (fire1) begin
			eof_s2 <= eof_s1;
		end
		if (fire2) begin
			out_s3.filtered         <= chain[0][OUT_LSB +: OUT_W];
			out_s3.end_of_frame_out <= eof_s2;
		end
	end

	assign chain[TAPS] = '0;

	for (genvar i = 0; i < TAPS; i++) begin : g_tap
		tfir_cell #(
			.COEF(tfir_coef(i))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.x      (sample_s1),
			.sum_in (chain[i+1]),
			.sum_out(chain[i])
		);
	end

	assign out_valid = valid_s3;
	assign out_item  = out_s3;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item not in sample register");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && valid_s3)
		else $error("input stalled with a free stage");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv3 |=> valid_s2 && $stable(eof_s2))
		else $error("product stage lost a stalled item");

	a_eof_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire2 |=> valid_s3 && out_s3.end_of_frame_out == $past(eof_s2))
		else $error("end-of-frame flag lost on output");

endmodule
`default_nettype wire
